### sv/cpt_pkg.sv
// ----------------------------------------------------------------------------
// cpt_pkg: shared types and constants for candidate proximity thinning
// Operation codes, register indexes, field widths and the request and
// response words exchanged with the distance unit.
// ----------------------------------------------------------------------------
package cpt_pkg;

    localparam int MAX_BUSY_DEF = 256;
    localparam int FRAC_BITS    = 4;

    localparam int COORD_W  = 12;
    localparam int ROOT_W   = 16;
    localparam int LEVEL_W  = 2;
    localparam int OP_W     = 2;
    localparam int DIST_W   = 24;
    localparam int CFG_IDX_W = 2;
    localparam int SHIFT_W  = 4;

    localparam logic [COORD_W-1:0] COORD_MAX     = '1;
    localparam logic [DIST_W-1:0]  MIN_DIST_RST  = DIST_W'(100);

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR = 2'd0,
        OP_ADD   = 2'd1,
        OP_TEST  = 2'd2
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET_LEVEL = 2'd0,
        CFG_MIN_DIST_SQ  = 2'd1
    } t_cfg_idx;

    typedef struct packed {
        logic               valid;
        logic [COORD_W-1:0] busy_x;
        logic [COORD_W-1:0] busy_y;
        logic [COORD_W-1:0] cand_x;
        logic [COORD_W-1:0] cand_y;
    } t_dist_req;

    typedef struct packed {
        logic valid;
        logic near;
    } t_dist_rsp;

endpackage

### sv/cpt_ifs.sv
// ----------------------------------------------------------------------------
// cpt_ifs: channel interfaces for candidate proximity thinning
// Input word channel, result word channel and register write channel.
// ----------------------------------------------------------------------------
interface cpt_in_if
    import cpt_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    op;
    logic [LEVEL_W-1:0] meas_level;
    logic [ROOT_W-1:0]  root_x;
    logic [ROOT_W-1:0]  root_y;
    logic [COORD_W-1:0] cand_x;
    logic [COORD_W-1:0] cand_y;

    modport source (output valid, op, meas_level, root_x, root_y, cand_x, cand_y,
                    input ready);
    modport sink   (input valid, op, meas_level, root_x, root_y, cand_x, cand_y,
                    output ready);
endinterface

interface cpt_out_if
    import cpt_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               keep;
    logic [COORD_W-1:0] out_x;
    logic [COORD_W-1:0] out_y;
    logic               busy_overflow;

    modport source (output valid, keep, out_x, out_y, busy_overflow, input ready);
    modport sink   (input valid, keep, out_x, out_y, busy_overflow, output ready);
endinterface

interface cpt_cfg_if
    import cpt_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DIST_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### sv/cpt_dist.sv
// ----------------------------------------------------------------------------
// cpt_dist: pipelined squared-distance compare unit
// Takes one busy position and the candidate per cycle, squares the absolute
// differences in a registered stage and flags a distance below the limit.
// ----------------------------------------------------------------------------
module cpt_dist
    import cpt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dist_req         i_req,
    input  logic [DIST_W-1:0] i_min_dist_sq,
    output t_dist_rsp         o_rsp
);

    logic [COORD_W-1:0]   w_dx;
    logic [COORD_W-1:0]   w_dy;
    logic [2*COORD_W-1:0] r_sq_x;
    logic [2*COORD_W-1:0] r_sq_y;
    logic                 r_valid;
    logic [2*COORD_W:0]   w_sum;

    assign w_dx = (i_req.busy_x >= i_req.cand_x) ? i_req.busy_x - i_req.cand_x
                                                 : i_req.cand_x - i_req.busy_x;
    assign w_dy = (i_req.busy_y >= i_req.cand_y) ? i_req.busy_y - i_req.cand_y
                                                 : i_req.cand_y - i_req.busy_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_req.valid;
        end
        r_sq_x <= (2*COORD_W)'(w_dx) * (2*COORD_W)'(w_dx);
        r_sq_y <= (2*COORD_W)'(w_dy) * (2*COORD_W)'(w_dy);
    end

    assign w_sum       = {1'b0, r_sq_x} + {1'b0, r_sq_y};
    assign o_rsp.valid = r_valid;
    assign o_rsp.near  = w_sum < (2*COORD_W+1)'(i_min_dist_sq);

endmodule

### sv/candidate_proximity_thinning_core.sv
// ----------------------------------------------------------------------------
// candidate_proximity_thinning_core: busy list and candidate thinning
// Keeps a list of busy positions scaled to the target pyramid level and
// tests candidates against every entry with one shared distance unit.
//
//   channel  | dir | word
//   ---------+-----+------------------------------------------------------
//   i_in     | in  | op, meas_level, root_x, root_y, cand_x, cand_y
//   o_out    | out | keep, out_x, out_y, busy_overflow (test words only)
//   i_cfg    | in  | index, data (target_level, min_dist_sq)
//
// Clear and add words complete on acceptance. A test word scans n stored positions,
// one per cycle, and its result is registered once the last response has come back
// (straight away for an empty list): a memory read, a squaring stage and a closing step.
// The input is not ready during a scan and is ready again the cycle after it ends;
// a scan that ends with the result register still full holds until it drains.
// Reset is synchronous and resets the count, flag, state and configuration, not the memory or data registers.
// ----------------------------------------------------------------------------
module candidate_proximity_thinning_core
    import cpt_pkg::*;
#(
    parameter int MAX_BUSY = MAX_BUSY_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    cpt_in_if.sink    i_in,
    cpt_out_if.source o_out,
    cpt_cfg_if.sink   i_cfg
);

    localparam int ADDR_W = (MAX_BUSY > 1) ? $clog2(MAX_BUSY) : 1;
    localparam int CNT_W  = $clog2(MAX_BUSY + 1);

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    t_state r_state;

    logic [LEVEL_W-1:0]   r_target_level;
    logic [DIST_W-1:0]    r_min_dist_sq;
    logic [CNT_W-1:0]     r_count;
    logic                 r_overflow;
    logic [CNT_W-1:0]     r_idx;
    logic                 r_rd_valid;
    logic [2*COORD_W-1:0] r_rd_data;
    logic [COORD_W-1:0]   r_cand_x;
    logic [COORD_W-1:0]   r_cand_y;
    logic                 r_keep;
    logic                 r_out_valid;
    logic                 r_out_keep;
    logic [COORD_W-1:0]   r_out_x;
    logic [COORD_W-1:0]   r_out_y;
    logic                 r_out_ovf;

    logic [2*COORD_W-1:0] mem [MAX_BUSY];

    logic               w_accept;
    logic               w_level_hit;
    logic               w_full;
    logic               w_add_wr;
    logic               w_issue;
    logic               w_scan_done;
    logic               w_load;
    logic [SHIFT_W-1:0] w_shift;
    logic [ROOT_W:0]    w_half;
    logic [ROOT_W:0]    w_sum_x;
    logic [ROOT_W:0]    w_sum_y;
    logic [ROOT_W:0]    w_shr_x;
    logic [ROOT_W:0]    w_shr_y;
    logic [COORD_W-1:0] w_pos_x;
    logic [COORD_W-1:0] w_pos_y;
    t_dist_req          w_req;
    t_dist_rsp          w_rsp;

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_accept    = i_in.valid && i_in.ready;

    // A measurement belongs to the list if it sits at the target level or one above.
    assign w_level_hit = ({1'b0, i_in.meas_level} == {1'b0, r_target_level}) ||
                         ({1'b0, i_in.meas_level} == {1'b0, r_target_level} + 3'd1);
    assign w_full      = (r_count == CNT_W'(MAX_BUSY));
    assign w_add_wr    = w_accept && (t_op'(i_in.op) == OP_ADD) && w_level_hit && !w_full;

    // Divide by 2^(FRAC_BITS + target_level), round half up, saturate.
    always_comb begin
        w_shift = SHIFT_W'(FRAC_BITS) + SHIFT_W'(r_target_level);
        w_half  = (w_shift == '0) ? '0 : ((ROOT_W+1)'(1) << (w_shift - SHIFT_W'(1)));
        w_sum_x = {1'b0, i_in.root_x} + w_half;
        w_sum_y = {1'b0, i_in.root_y} + w_half;
        w_shr_x = w_sum_x >> w_shift;
        w_shr_y = w_sum_y >> w_shift;
        w_pos_x = (w_shr_x > (ROOT_W+1)'(COORD_MAX)) ? COORD_MAX : w_shr_x[COORD_W-1:0];
        w_pos_y = (w_shr_y > (ROOT_W+1)'(COORD_MAX)) ? COORD_MAX : w_shr_y[COORD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_add_wr) begin
            mem[r_count[ADDR_W-1:0]] <= {w_pos_x, w_pos_y};
        end
        r_rd_data <= mem[r_idx[ADDR_W-1:0]];
    end

    assign w_issue     = (r_state == S_SCAN) && (r_idx < r_count);
    assign w_scan_done = (r_state == S_SCAN) && !w_issue && !r_rd_valid && !w_rsp.valid;
    assign w_load      = w_scan_done && (!r_out_valid || o_out.ready);

    assign w_req.valid  = r_rd_valid;
    assign w_req.busy_x = r_rd_data[2*COORD_W-1:COORD_W];
    assign w_req.busy_y = r_rd_data[COORD_W-1:0];
    assign w_req.cand_x = r_cand_x;
    assign w_req.cand_y = r_cand_y;

    cpt_dist u_dist (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (w_req),
        .i_min_dist_sq (r_min_dist_sq),
        .o_rsp         (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_target_level <= '0;
            r_min_dist_sq  <= MIN_DIST_RST;
            r_count        <= '0;
            r_overflow     <= 1'b0;
            r_idx          <= '0;
            r_rd_valid     <= 1'b0;
            r_keep         <= 1'b1;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                unique case (t_cfg_idx'(i_cfg.index))
                    CFG_TARGET_LEVEL: r_target_level <= i_cfg.data[LEVEL_W-1:0];
                    CFG_MIN_DIST_SQ:  r_min_dist_sq  <= i_cfg.data;
                    default: ;
                endcase
            end

            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            r_rd_valid <= w_issue;

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        unique case (t_op'(i_in.op))
                            OP_CLEAR: begin
                                r_count    <= '0;
                                r_overflow <= 1'b0;
                            end
                            OP_ADD: begin
                                if (w_level_hit) begin
                                    if (w_full) begin
                                        r_overflow <= 1'b1;
                                    end else begin
                                        r_count <= r_count + CNT_W'(1);
                                    end
                                end
                            end
                            OP_TEST: begin
                                r_cand_x <= i_in.cand_x;
                                r_cand_y <= i_in.cand_y;
                                r_idx    <= '0;
                                r_keep   <= 1'b1;
                                r_state  <= S_SCAN;
                            end
                            default: ;
                        endcase
                    end
                end
                S_SCAN: begin
                    if (w_issue) begin
                        r_idx <= r_idx + CNT_W'(1);
                    end
                    if (w_rsp.valid && w_rsp.near) begin
                        r_keep <= 1'b0;
                    end
                    if (w_load) begin
                        r_out_keep  <= r_keep;
                        r_out_x     <= r_cand_x;
                        r_out_y     <= r_cand_y;
                        r_out_ovf   <= r_overflow;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.keep          = r_out_keep;
    assign o_out.out_x         = r_out_x;
    assign o_out.out_y         = r_out_y;
    assign o_out.busy_overflow = r_out_ovf;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_BUSY))
        else $error("busy count exceeds list depth");

    a_ovf_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_overflow) |-> $past(w_full))
        else $error("overflow set while the list had room");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (t_op'(i_in.op) == OP_CLEAR)) |=> (r_count == '0) && !r_overflow)
        else $error("clear did not empty the busy list");

    a_dist_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rd_valid || w_rsp.valid) |-> (r_state == S_SCAN))
        else $error("distance pipeline active outside a scan");

    a_load_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> (r_idx == r_count))
        else $error("result loaded before every entry was scanned");
`endif

endmodule
